>>> hw/rtl/lva_pkg.sv
// Shared types and constants of the LRU voice allocator.
package lva_pkg;

  localparam int unsigned DEF_MAX_VOICES = 16;
  localparam int unsigned RESET_VOICES   = 16;
  localparam int unsigned VCNT_W         = 5;
  localparam int unsigned VOICE_IDX_W    = 4;
  localparam int unsigned KEY_W          = 7;
  localparam int unsigned VEL_W          = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_RANK,
    ST_PROMO
  } lva_state_e;

  // per-voice write command: gate and, optionally, a new key
  typedef struct packed {
    logic             en;
    logic             gate;
    logic             key_we;
    logic [KEY_W-1:0] key;
  } lva_vwr_t;

  // registered read of one voice
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             key_valid;
    logic             gate;
  } lva_rd_t;

endpackage

>>> hw/rtl/lva_store.sv
// Voice state store: key and rank memories plus valid and gate flag vectors.
module lva_store #(
  parameter int unsigned MAX_VOICES = lva_pkg::DEF_MAX_VOICES,
  localparam int unsigned IDX_W     = $clog2(MAX_VOICES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output lva_pkg::lva_rd_t      rd_o,
  output logic [IDX_W-1:0]      rank_rd_o,
  input  logic [IDX_W-1:0]      vwr_addr_i,
  input  lva_pkg::lva_vwr_t     vwr_i,
  input  logic                  rwr_en_i,
  input  logic [IDX_W-1:0]      rwr_addr_i,
  input  logic [IDX_W-1:0]      rwr_rank_i
);
  import lva_pkg::*;

  logic [KEY_W-1:0]      key_mem  [MAX_VOICES];
  logic [IDX_W-1:0]      rank_mem [MAX_VOICES];
  logic [MAX_VOICES-1:0] key_valid_q;
  logic [MAX_VOICES-1:0] gate_q;
  logic [MAX_VOICES-1:0] rank_vld_q;
  lva_rd_t               rd_q;
  logic [IDX_W-1:0]      rank_rd_q;

  // flag vectors; an unwritten rank reads as its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_valid_q <= '0;
      gate_q      <= '0;
      rank_vld_q  <= '0;
    end else if (clear_i) begin
      key_valid_q <= '0;
      gate_q      <= '0;
      rank_vld_q  <= '0;
    end else begin
      if (vwr_i.en) begin
        gate_q[vwr_addr_i] <= vwr_i.gate;
        if (vwr_i.key_we) begin
          key_valid_q[vwr_addr_i] <= 1'b1;
        end
      end
      if (rwr_en_i) begin
        rank_vld_q[rwr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr_i.en && vwr_i.key_we) begin
      key_mem[vwr_addr_i] <= vwr_i.key;
    end
    if (rwr_en_i) begin
      rank_mem[rwr_addr_i] <= rwr_rank_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.key       <= key_mem[rd_addr_i];
      rd_q.key_valid <= key_valid_q[rd_addr_i];
      rd_q.gate      <= gate_q[rd_addr_i];
      rank_rd_q      <= rank_vld_q[rd_addr_i] ? rank_mem[rd_addr_i] : rd_addr_i;
    end
  end

  assign rd_o      = rd_q;
  assign rank_rd_o = rank_rd_q;

endmodule

>>> hw/rtl/lru_voice_allocator_core.sv
// LRU polyphonic voice allocator: pass sequencer, shared rank comparator, result register.
// One transaction at a time. Busy after accept for the key pass alone on a note-off or
// a note-on of a held key, and for the key, rank and promote passes on a new allocation,
// every pass paced by the store's single registered read port (one voice per cycle).
// The result strobe is high in the first cycle after busy falls, none for an unheld note-off.
// Async active-low reset: gates and key valids cleared, ranks equal voice index, count 16
// (limited to MAX_VOICES). A voice-count write reinitializes the same state at once.
module lru_voice_allocator_core #(
  parameter int unsigned MAX_VOICES = lva_pkg::DEF_MAX_VOICES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lva_pkg::VCNT_W-1:0]    cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          gate_i,
  input  logic [lva_pkg::KEY_W-1:0]     key_i,
  input  logic [lva_pkg::VEL_W-1:0]     velocity_i,
  output logic                          valid_o,
  output logic [lva_pkg::VOICE_IDX_W-1:0] voice_index_o,
  output logic                          gate_out_o,
  output logic [lva_pkg::KEY_W-1:0]     key_out_o,
  output logic [lva_pkg::VEL_W-1:0]     velocity_out_o,
  output logic                          stolen_o
);
  import lva_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_VOICES);
  localparam int unsigned CNT_W = $clog2(MAX_VOICES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VOICES);
  localparam logic [CNT_W-1:0] CNT_RST =
    CNT_W'((RESET_VOICES > MAX_VOICES) ? MAX_VOICES : RESET_VOICES);

  lva_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] addr_q, addr_d;     // next voice to read
  logic             pv_q, pv_d;         // read data valid this cycle
  logic [IDX_W-1:0] pi_q, pi_d;         // voice index of that read data
  logic             gate_q, gate_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VEL_W-1:0] vel_q, vel_d;
  logic             found_q, found_d;
  logic             any_free_q, any_free_d;
  logic             best_vld_q, best_vld_d;
  logic [IDX_W-1:0] chosen_q, chosen_d;
  logic [IDX_W-1:0] best_rank_q, best_rank_d;  // old rank of the chosen voice
  logic             stolen_q, stolen_d;

  logic             valid_q, valid_d;
  logic [IDX_W-1:0] o_idx_q, o_idx_d;
  logic             o_gate_q, o_gate_d;
  logic [KEY_W-1:0] o_key_q, o_key_d;
  logic [VEL_W-1:0] o_vel_q, o_vel_d;
  logic             o_stolen_q, o_stolen_d;

  // store interface
  logic             rd_en;
  lva_rd_t          rd;
  logic [IDX_W-1:0] rank_rd;
  lva_vwr_t         vwr;
  logic             rwr_en;
  logic [IDX_W-1:0] rwr_rank;

  // shared rank comparator: rank pass asks rank > best, promote pass asks old > rank
  logic [IDX_W-1:0] cmp_a, cmp_b;
  logic             cmp_gt;

  logic             scan_issue, pass_end, cand;
  logic [IDX_W+VOICE_IDX_W-1:0] idx_ext;

  lva_store #(
    .MAX_VOICES(MAX_VOICES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (addr_q[IDX_W-1:0]),
    .rd_o       (rd),
    .rank_rd_o  (rank_rd),
    .vwr_addr_i (chosen_q),
    .vwr_i      (vwr),
    .rwr_en_i   (rwr_en),
    .rwr_addr_i (pi_q),
    .rwr_rank_i (rwr_rank)
  );

  // voice-count write: 0 means one voice, large values saturate at MAX_VOICES
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cnt_d = CNT_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(MAX_VOICES)) begin
        cnt_d = CNT_MAX;
      end else begin
        cnt_d = CNT_W'(cfg_wdata_i);
      end
    end
  end

  assign cmp_a  = (state_q == ST_RANK) ? rank_rd : best_rank_q;
  assign cmp_b  = (state_q == ST_RANK) ? best_rank_q : rank_rd;
  assign cmp_gt = cmp_a > cmp_b;

  assign scan_issue = addr_q < cnt_q;
  assign pass_end   = !scan_issue && !pv_q;
  // on a steal every voice is a candidate, otherwise only released ones
  assign cand       = !any_free_q || !rd.gate;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    pv_d        = pv_q;
    pi_d        = pi_q;
    gate_d      = gate_q;
    key_d       = key_q;
    vel_d       = vel_q;
    found_d     = found_q;
    any_free_d  = any_free_q;
    best_vld_d  = best_vld_q;
    chosen_d    = chosen_q;
    best_rank_d = best_rank_q;
    stolen_d    = stolen_q;
    valid_d     = 1'b0;
    o_idx_d     = o_idx_q;
    o_gate_d    = o_gate_q;
    o_key_d     = o_key_q;
    o_vel_d     = o_vel_q;
    o_stolen_d  = o_stolen_q;
    rd_en       = 1'b0;
    vwr         = '0;
    rwr_en      = 1'b0;
    rwr_rank    = '0;

    // common scan walker for the three passes
    if (state_q != ST_IDLE) begin
      if (scan_issue) begin
        rd_en  = 1'b1;
        addr_d = addr_q + CNT_W'(1);
        pv_d   = 1'b1;
        pi_d   = addr_q[IDX_W-1:0];
      end else begin
        pv_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          gate_d     = gate_i;
          key_d      = key_i;
          vel_d      = velocity_i;
          addr_d     = '0;
          pv_d       = 1'b0;
          found_d    = 1'b0;
          any_free_d = 1'b0;
          state_d    = ST_KEY;
        end
      end

      ST_KEY: begin
        if (pv_q) begin
          if (!found_q && rd.key_valid && rd.key == key_q) begin
            found_d  = 1'b1;
            chosen_d = pi_q;
          end
          if (!rd.gate) begin
            any_free_d = 1'b1;
          end
        end
        if (pass_end) begin
          if (found_q) begin
            // held key: gate it on or off in place, ranks untouched
            vwr.en     = 1'b1;
            vwr.gate   = gate_q;
            valid_d    = 1'b1;
            o_idx_d    = chosen_q;
            o_gate_d   = gate_q;
            o_key_d    = key_q;
            o_vel_d    = gate_q ? vel_q : '0;
            o_stolen_d = 1'b0;
            state_d    = ST_IDLE;
          end else if (!gate_q) begin
            state_d = ST_IDLE;  // note-off for a key nobody holds
          end else begin
            addr_d     = '0;
            best_vld_d = 1'b0;
            state_d    = ST_RANK;
          end
        end
      end

      ST_RANK: begin
        if (pv_q && cand && (!best_vld_q || cmp_gt)) begin
          best_vld_d  = 1'b1;
          chosen_d    = pi_q;
          best_rank_d = rank_rd;
        end
        if (pass_end) begin
          stolen_d = !any_free_q;
          addr_d   = '0;
          state_d  = ST_PROMO;
        end
      end

      ST_PROMO: begin
        if (pv_q) begin
          if (pi_q == chosen_q) begin
            rwr_en   = 1'b1;
            rwr_rank = '0;
          end else if (cmp_gt) begin
            rwr_en   = 1'b1;
            rwr_rank = rank_rd + IDX_W'(1);
          end
        end
        if (pass_end) begin
          vwr.en     = 1'b1;
          vwr.gate   = 1'b1;
          vwr.key_we = 1'b1;
          vwr.key    = key_q;
          valid_d    = 1'b1;
          o_idx_d    = chosen_q;
          o_gate_d   = 1'b1;
          o_key_d    = key_q;
          o_vel_d    = vel_q;
          o_stolen_d = stolen_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= CNT_RST;
      addr_q     <= '0;
      pv_q       <= 1'b0;
      found_q    <= 1'b0;
      any_free_q <= 1'b0;
      best_vld_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      addr_q     <= addr_d;
      pv_q       <= pv_d;
      found_q    <= found_d;
      any_free_q <= any_free_d;
      best_vld_q <= best_vld_d;
      valid_q    <= valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pi_q        <= pi_d;
    gate_q      <= gate_d;
    key_q       <= key_d;
    vel_q       <= vel_d;
    chosen_q    <= chosen_d;
    best_rank_q <= best_rank_d;
    stolen_q    <= stolen_d;
    o_idx_q     <= o_idx_d;
    o_gate_q    <= o_gate_d;
    o_key_q     <= o_key_d;
    o_vel_q     <= o_vel_d;
    o_stolen_q  <= o_stolen_d;
  end

  // voice index reported modulo the 4-bit field
  assign idx_ext        = {{VOICE_IDX_W{1'b0}}, o_idx_q};
  assign busy           = (state_q != ST_IDLE);
  assign valid_o        = valid_q;
  assign voice_index_o  = idx_ext[VOICE_IDX_W-1:0];
  assign gate_out_o     = o_gate_q;
  assign key_out_o      = o_key_q;
  assign velocity_out_o = o_vel_q;
  assign stolen_o       = o_stolen_q;

  // a result only ever follows the end of a pass
  a_result_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) != ST_IDLE)
    else $error("result strobe without a finished transaction");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a pass");

  // the voice being promoted lies inside the active set
  a_chosen_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROMO) |-> ({1'b0, chosen_q} < {1'b0, cnt_q}))
    else $error("chosen voice outside the active voices");

  // a steal is only ever reported for a note-on
  a_steal_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && o_stolen_q) |-> o_gate_q)
    else $error("steal flagged on a note-off");

endmodule
